>>> hw/rtl/b32g_pkg.sv
package b32g_pkg;

  // Group geometry
  localparam int unsigned GROUP_NIBBLES = 5;
  localparam int unsigned ACC_W         = 20;
  localparam int unsigned DIGIT_W       = 5;
  localparam int unsigned LEFT_W        = 3;
  localparam int unsigned TOTAL_W       = 12;
  localparam int unsigned CHAR_W        = 7;

  // Group queue between front and back
  localparam int unsigned QUEUE_DEPTH   = 4;
  localparam int unsigned QPTR_W        = 2;
  localparam int unsigned QCNT_W        = 3;

  localparam logic [LEFT_W-1:0] LEFT_FULL = 3'd5;

  // One completed group: its value and the index of its leading digit
  typedef struct packed {
    logic [ACC_W-1:0] value;
    logic [1:0]       last_idx;
  } group_t;

  // Remainder by five: 16 is 1 mod 5, so nibble sums keep the remainder
  function automatic logic [2:0] mod5(input logic [TOTAL_W-1:0] x);
    logic [5:0] s1;
    logic [4:0] s2;
    s1 = {2'b00, x[11:8]} + {2'b00, x[7:4]} + {2'b00, x[3:0]};
    s2 = {3'b000, s1[5:4]} + {1'b0, s1[3:0]};
    if (s2 >= 5'd15) s2 = s2 - 5'd15;
    if (s2 >= 5'd10) s2 = s2 - 5'd10;
    if (s2 >= 5'd5)  s2 = s2 - 5'd5;
    return s2[2:0];
  endfunction

  // Base32 digit to ASCII: '0'-'9' then 'a'-'v'
  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 5'd10) c = 7'd48 + {2'b00, d};
    else           c = 7'd87 + {2'b00, d};
    return c;
  endfunction

  // Index of the leading digit; a zero group prints all four digits
  function automatic logic [1:0] lead_idx(input logic [ACC_W-1:0] v);
    logic [1:0] r;
    if (v == '0 || v[19:15] != '0) r = 2'd3;
    else if (v[14:10] != '0)       r = 2'd2;
    else if (v[9:5] != '0)         r = 2'd1;
    else                           r = 2'd0;
    return r;
  endfunction

endpackage

>>> hw/rtl/b32g_front.sv
module b32g_front #(
  parameter int unsigned MAX_MESSAGE_NIBBLES = 4095
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic [3:0]                        nibble,
  input  logic                              start_req,
  input  logic [b32g_pkg::TOTAL_W-1:0]      total_nibbles,
  input  logic                              q_full,
  output logic                              q_push,
  output b32g_pkg::group_t                  q_data
);

  localparam int unsigned MAX_CLAMP = (MAX_MESSAGE_NIBBLES > 4095) ? 4095 : MAX_MESSAGE_NIBBLES;
  localparam logic [b32g_pkg::TOTAL_W-1:0] MAX_TOTAL = MAX_CLAMP[b32g_pkg::TOTAL_W-1:0];

  logic [b32g_pkg::ACC_W-1:0]  acc;
  logic [b32g_pkg::ACC_W-1:0]  acc_next;
  logic [b32g_pkg::LEFT_W-1:0] left;
  logic [b32g_pkg::LEFT_W-1:0] left_next;

  logic                          accept;
  logic [b32g_pkg::TOTAL_W-1:0]  total_sat;
  logic [2:0]                    rem;
  logic [b32g_pkg::LEFT_W-1:0]   left_eff;
  logic [b32g_pkg::LEFT_W-1:0]   left_dec;
  logic [b32g_pkg::ACC_W-1:0]    acc_base;
  logic [b32g_pkg::ACC_W-1:0]    acc_shift;

  assign accept = push && !q_full;

  // Size of the current group (from the announced length on a start) and the shifted word
  always_comb begin
    total_sat = (total_nibbles > MAX_TOTAL) ? MAX_TOTAL : total_nibbles;
    rem       = b32g_pkg::mod5(total_sat);
    if (start_req) left_eff = (rem == 3'd0) ? b32g_pkg::LEFT_FULL : rem;
    else           left_eff = left;
    if (left_eff == '0 || left_eff > b32g_pkg::LEFT_FULL) left_eff = b32g_pkg::LEFT_FULL;
    left_dec  = left_eff - 3'd1;
    acc_base  = start_req ? '0 : acc;
    acc_shift = {acc_base[b32g_pkg::ACC_W-5:0], nibble};
  end

  // Gather nibbles; hand a completed group to the queue
  always_comb begin
    acc_next  = acc;
    left_next = left;
    q_push    = 1'b0;
    if (accept) begin
      if (left_dec == '0) begin
        q_push    = 1'b1;
        acc_next  = '0;
        left_next = b32g_pkg::LEFT_FULL;
      end else begin
        acc_next  = acc_shift;
        left_next = left_dec;
      end
    end
  end

  assign q_data.value    = acc_shift;
  assign q_data.last_idx = b32g_pkg::lead_idx(acc_shift);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      left <= '0;
    end else begin
      acc  <= acc_next;
      left <= left_next;
    end
  end

  // Count never leaves 0..5
  a_left_range: assert property (@(posedge clk) disable iff (rst)
    left <= b32g_pkg::LEFT_FULL)
    else $error("group counter out of range");

  // A group is handed over only with room in the queue
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("group pushed into full queue");

endmodule

>>> hw/rtl/b32g_queue.sv
module b32g_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  b32g_pkg::group_t  wr_data,
  output logic              full,
  input  logic              rd_en,
  output b32g_pkg::group_t  rd_data,
  output logic              empty
);

  b32g_pkg::group_t                 mem [b32g_pkg::QUEUE_DEPTH];
  logic [b32g_pkg::QPTR_W-1:0]      wr_ptr;
  logic [b32g_pkg::QPTR_W-1:0]      rd_ptr;
  logic [b32g_pkg::QCNT_W-1:0]      count;
  logic                             do_wr;
  logic                             do_rd;

  assign full    = (count == b32g_pkg::QUEUE_DEPTH[b32g_pkg::QCNT_W-1:0]);
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr] <= wr_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd)      count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= b32g_pkg::QUEUE_DEPTH[b32g_pkg::QCNT_W-1:0])
    else $error("queue count overflow");

endmodule

>>> hw/rtl/b32g_back.sv
module b32g_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  input  b32g_pkg::group_t              q_data,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic [b32g_pkg::CHAR_W-1:0]   character,
  output logic                          group_last
);

  // Working group and its current digit index
  logic [b32g_pkg::ACC_W-1:0] work_val;
  logic [1:0]                 idx;
  logic                       work_valid;
  logic                       out_valid;

  logic                           out_free;
  logic                           adv;
  logic                           work_done;
  logic [b32g_pkg::DIGIT_W-1:0]   digit;

  assign out_free  = !out_valid || pop;
  assign adv       = work_valid && out_free;
  assign work_done = adv && (idx == 2'd0);
  assign q_pop     = !q_empty && (!work_valid || work_done);
  assign empty     = !out_valid;

  // Digit pick, most significant first
  always_comb begin
    case (idx)
      2'd3:    digit = work_val[19:15];
      2'd2:    digit = work_val[14:10];
      2'd1:    digit = work_val[9:5];
      default: digit = work_val[4:0];
    endcase
  end

  // Work register control
  always_ff @(posedge clk) begin
    if (rst) begin
      work_valid <= 1'b0;
    end else if (q_pop) begin
      work_valid <= 1'b1;
    end else if (work_done) begin
      work_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      work_val <= q_data.value;
      idx      <= q_data.last_idx;
    end else if (adv) begin
      idx      <= idx - 2'd1;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= adv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      character  <= b32g_pkg::digit_char(digit);
      group_last <= (idx == 2'd0);
    end
  end

  // Last flag follows the final digit of the working group
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    adv |=> (group_last == $past(idx == 2'd0)))
    else $error("group_last mismatch");

  // A word is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !pop) |=> out_valid)
    else $error("pending word dropped");

endmodule

>>> hw/rtl/nibble_to_base32_grouper.sv
// A group is queued with its last nibble; its characters then pass the back end's work and
// output registers. One nibble a cycle goes in while full is low; one character a cycle comes
// out while pop is high, set by the back end. A 4-entry group queue parts front and back;
// full rises only when it is full. Reset (rst, synchronous, active high) empties the queue
// and clears the group accumulator and counter; the first group after reset holds 5 nibbles.
module nibble_to_base32_grouper #(
  parameter int unsigned MAX_MESSAGE_NIBBLES = 4095
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [3:0]                       nibble,
  input  logic                             start_req,
  input  logic [b32g_pkg::TOTAL_W-1:0]     total_nibbles,
  output logic                             empty,
  input  logic                             pop,
  output logic [b32g_pkg::CHAR_W-1:0]      character,
  output logic                             group_last
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  b32g_pkg::group_t q_wdata;
  b32g_pkg::group_t q_rdata;

  assign full = q_full;

  b32g_front #(
    .MAX_MESSAGE_NIBBLES(MAX_MESSAGE_NIBBLES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .nibble       (nibble),
    .start_req    (start_req),
    .total_nibbles(total_nibbles),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  b32g_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (q_push),
    .wr_data(q_wdata),
    .full   (q_full),
    .rd_en  (q_pop),
    .rd_data(q_rdata),
    .empty  (q_empty)
  );

  b32g_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .character (character),
    .group_last(group_last)
  );

endmodule

>>> tb/b32g_char_checker.sv
module b32g_char_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  logic [3:0]                      nibble,
  input  logic                            start_req,
  input  logic [b32g_pkg::TOTAL_W-1:0]    total_nibbles,
  input  logic                            empty,
  input  logic                            pop,
  input  logic [b32g_pkg::CHAR_W-1:0]     character,
  input  logic                            group_last,
  output int                              mismatches,
  output int                              chars_waiting,
  output int                              chars_seen,
  output int                              groups_seen
);

  typedef struct packed {
    logic [b32g_pkg::CHAR_W-1:0] ch;
    logic                        last;
  } b32_char_t;

  localparam logic [b32g_pkg::CHAR_W-1:0] ASCII_ZERO = 7'd48;
  localparam logic [b32g_pkg::CHAR_W-1:0] ASCII_A    = 7'd97;
  localparam int                          LEN_LIMIT  = 4095;
  localparam int                          SHOWN_MAX  = 10;

  // characters still owed by the block, oldest first
  b32_char_t due_chars[$];

  // own copy of the grouping state
  logic [b32g_pkg::ACC_W-1:0]  grp_acc;
  logic [b32g_pkg::LEFT_W-1:0] grp_left;
  int                          n_bad  = 0;
  int                          n_char = 0;
  int                          n_grp  = 0;

  function automatic logic [b32g_pkg::CHAR_W-1:0] b32_ascii(
      input logic [b32g_pkg::DIGIT_W-1:0] d);
    if (d < 5'd10) return ASCII_ZERO + {2'b00, d};
    return ASCII_A + ({2'b00, d} - 7'd10);
  endfunction

  // Queue the characters of one finished group, leading digit first
  task automatic queue_group(input logic [b32g_pkg::ACC_W-1:0] v);
    int        nd;
    b32_char_t c;
    nd = 4;
    // non-zero groups lose their leading zero digits; zero prints all four
    if (v != '0) begin
      while (nd > 1 && v[5*nd-1 -: 5] == '0) nd--;
    end
    for (int k = nd - 1; k >= 0; k--) begin
      c.ch   = b32_ascii(v[5*k +: 5]);
      c.last = (k == 0);
      due_chars.push_back(c);
    end
  endtask

  // Fold one accepted word into the group state
  task automatic take_nibble(input logic [3:0] nib, input logic st,
                             input logic [b32g_pkg::TOTAL_W-1:0] tot);
    int                          len;
    int                          rem;
    logic [b32g_pkg::LEFT_W-1:0] cnt;
    if (st) begin
      len = int'(tot);
      if (len > LEN_LIMIT) len = LEN_LIMIT;
      rem = len % b32g_pkg::GROUP_NIBBLES;
      grp_left = (rem == 0) ? b32g_pkg::LEFT_FULL : b32g_pkg::LEFT_W'(rem);
      grp_acc  = '0;
    end
    // no message yet, or a nonsense count: group by five
    cnt = (grp_left == '0 || grp_left > b32g_pkg::LEFT_FULL) ? b32g_pkg::LEFT_FULL
                                                              : grp_left;
    grp_acc = {grp_acc[b32g_pkg::ACC_W-5:0], nib};
    cnt = cnt - 1'b1;
    if (cnt == '0) begin
      queue_group(grp_acc);
      grp_acc  = '0;
      grp_left = b32g_pkg::LEFT_FULL;
    end else begin
      grp_left = cnt;
    end
  endtask

  always @(posedge clk) begin : watch_channels
    b32_char_t want;
    if (rst) begin
      due_chars.delete();
      grp_acc  = '0;
      grp_left = '0;
    end else begin
      // result side first: a word popped now cannot stem from this edge's push
      if (pop && !empty) begin
        n_char++;
        if (group_last) n_grp++;
        if (due_chars.size() == 0) begin
          n_bad++;
          if (n_bad <= SHOWN_MAX)
            $display("%0t: unexpected character %0d last %0b", $realtime,
                     character, group_last);
        end else begin
          want = due_chars.pop_front();
          if (character !== want.ch) begin
            n_bad++;
            if (n_bad <= SHOWN_MAX)
              $display("%0t: character exp %0d got %0d", $realtime, want.ch, character);
          end
          if (group_last !== want.last) begin
            n_bad++;
            if (n_bad <= SHOWN_MAX)
              $display("%0t: group_last exp %0b got %0b", $realtime, want.last,
                       group_last);
          end
        end
      end
      if (push && !full) take_nibble(nibble, start_req, total_nibbles);
    end
    mismatches    <= n_bad;
    chars_waiting <= due_chars.size();
    chars_seen    <= n_char;
    groups_seen   <= n_grp;
  end

endmodule

>>> tb/tb_top.sv
module tb_top;

  localparam int NIBBLES_WANTED = 480;
  localparam int CALM_FROM      = 400;
  localparam int HOLD_AT        = 150;
  localparam int PAUSE_AT       = 280;
  localparam int HOLD_CYCLES    = 300;
  localparam int BURST_WORDS    = 40;
  localparam int TAIL_CYCLES    = 10;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         push;
  logic                         full;
  logic [3:0]                   nibble;
  logic                         start_req;
  logic [b32g_pkg::TOTAL_W-1:0] total_nibbles;
  logic                         empty;
  logic                         pop;
  logic [b32g_pkg::CHAR_W-1:0]  character;
  logic                         group_last;

  int mismatches, chars_waiting, chars_seen, groups_seen;
  int nibbles_sent  = 0;
  int messages_sent = 0;
  bit calm     = 1'b0;
  bit steady   = 1'b0;
  bit hold_req = 1'b0;
  bit holding  = 1'b0;

  always #4 clk = ~clk;

  nibble_to_base32_grouper u_dut (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .nibble        (nibble),
    .start_req     (start_req),
    .total_nibbles (total_nibbles),
    .empty         (empty),
    .pop           (pop),
    .character     (character),
    .group_last    (group_last)
  );

  b32g_char_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .nibble        (nibble),
    .start_req     (start_req),
    .total_nibbles (total_nibbles),
    .empty         (empty),
    .pop           (pop),
    .character     (character),
    .group_last    (group_last),
    .mismatches    (mismatches),
    .chars_waiting (chars_waiting),
    .chars_seen    (chars_seen),
    .groups_seen   (groups_seen)
  );

  // Offer one word, with an occasional idle burst ahead of it
  task automatic send_word(input logic [3:0] n, input logic st,
                           input logic [b32g_pkg::TOTAL_W-1:0] tot);
    if (!calm && !steady && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    push          <= 1'b1;
    nibble        <= n;
    start_req     <= st;
    total_nibbles <= tot;
    @(posedge clk);
    while (full) @(posedge clk);
    nibbles_sent++;
  endtask

  // Stop offering until every owed character has been popped
  task automatic wait_drained();
    push <= 1'b0;
    repeat (2) @(posedge clk);
    while (chars_waiting != 0) @(posedge clk);
  endtask

  // One message: mostly well formed, sometimes cut short or overrun
  task automatic send_message();
    logic [b32g_pkg::TOTAL_W-1:0] len;
    logic [3:0]                   n;
    int                           count;
    int                           extra;
    int                           style;
    if ($urandom_range(0, 7) == 0) len = b32g_pkg::TOTAL_W'($urandom_range(0, 4095));
    else                           len = b32g_pkg::TOTAL_W'($urandom_range(1, 24));
    count = int'(len);
    if (count == 0 || count > BURST_WORDS) count = $urandom_range(1, BURST_WORDS);
    if ($urandom_range(0, 9) == 0) count = $urandom_range(1, count);
    extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 0;
    style = $urandom_range(0, 3);
    for (int i = 0; i < count + extra; i++) begin
      case (style)
        2:       n = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'h0;
        3:       n = 4'h0;
        default: n = 4'($urandom_range(0, 15));
      endcase
      send_word(n, i == 0,
                (i == 0) ? len : b32g_pkg::TOTAL_W'($urandom_range(0, 4095)));
    end
    messages_sent++;
  endtask

  // Result side: stall bursts, plus one long hold-off on request
  initial begin : pop_driver
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        holding  = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holding = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    bit held;
    bit paused;
    held          = 1'b0;
    paused        = 1'b0;
    rst           <= 1'b1;
    push          <= 1'b0;
    nibble        <= '0;
    start_req     <= 1'b0;
    total_nibbles <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no message started: groups of five, all ones gives four top digits
    repeat (5) send_word(4'hf, 1'b0, 12'd0);
    // one-nibble message
    send_word(4'h1, 1'b1, 12'd1);
    // longest length, remainder zero: five nibbles with leading zeros
    send_word(4'h0, 1'b1, 12'd4095);
    send_word(4'h0, 1'b0, 12'd0);
    send_word(4'h0, 1'b0, 12'd0);
    send_word(4'h2, 1'b0, 12'd0);
    send_word(4'h0, 1'b0, 12'd0);
    // zero length also means five, top bit alone set
    send_word(4'h8, 1'b1, 12'd0);
    repeat (4) send_word(4'h0, 1'b0, 12'hfff);
    // two-nibble first group
    send_word(4'ha, 1'b1, 12'd7);
    send_word(4'h5, 1'b0, 12'd0);
    // a start abandons a part-built group
    send_word(4'hc, 1'b1, 12'd3);
    send_word(4'hf, 1'b1, 12'd4);
    repeat (3) send_word(4'hf, 1'b0, 12'd0);
    // past the end, then restart with a zero single nibble
    send_word(4'h3, 1'b0, 12'h555);
    send_word(4'h7, 1'b0, 12'haaa);
    send_word(4'h0, 1'b1, 12'd1);
    wait_drained();

    while (nibbles_sent < NIBBLES_WANTED) begin
      if (nibbles_sent >= CALM_FROM) calm = 1'b1;
      if (!held && nibbles_sent >= HOLD_AT) begin
        // output held off while words keep coming, so the queue fills
        push <= 1'b0;
        hold_req = 1'b1;
        while (!holding) @(posedge clk);
        steady = 1'b1;
        for (int i = 0; i < BURST_WORDS; i++)
          send_word(4'($urandom_range(0, 15)), i == 0,
                    b32g_pkg::TOTAL_W'(BURST_WORDS));
        steady = 1'b0;
        held   = 1'b1;
      end
      if (!paused && nibbles_sent >= PAUSE_AT) begin
        wait_drained();
        paused = 1'b1;
      end
      if ($urandom_range(0, 9) == 0) begin
        // stray words with no start
        repeat ($urandom_range(1, 6))
          send_word(4'($urandom_range(0, 15)), 1'b0,
                    b32g_pkg::TOTAL_W'($urandom_range(0, 4095)));
      end else begin
        send_message();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d nibbles over %0d messages, with stray, cut-short and overrun runs.",
             nibbles_sent, messages_sent);
    $display("Checked %0d characters in %0d groups, through a long output hold and a drain.",
             chars_seen, groups_seen);
    if (mismatches == 0 && chars_waiting == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(8 * 200000);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
